// File: design/trial_division_prime_test_macros.svh
// assertion macros used by the checker in tdp_checker.sv
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

// concurrent check that is off while reset is held
`define TDP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("trial division prime test: check failed");

// concurrent check that also runs during reset
`define TDP_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("trial division prime test: check failed");

`endif

// File: design/tdp_pkg.sv
package tdp_pkg;

	// class given to a word by the front end
	typedef enum logic [1:0] {
		CLS_COMPOSITE = 2'd0,
		CLS_PRIME     = 2'd1,
		CLS_SEARCH    = 2'd2
	} cls_t;

	// back end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EVAL = 3'b100
	} state_t;

	// head of the queue as seen by the back end
	typedef struct packed {
		logic valid;
		cls_t cls;
	} tdp_entry_t;

	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

// File: design/tdp_front.sv
module tdp_front import tdp_pkg::*; #(
	parameter int NUM_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 number_valid,
	output logic                 number_stall,
	input  logic [NUM_WIDTH-1:0] number,
	output tdp_entry_t           entry,
	output logic [NUM_WIDTH-1:0] entry_number,
	input  logic                 entry_pop
);

	logic [NUM_WIDTH-1:0] num_q [QUEUE_DEPTH];
	cls_t                 cls_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [QCNT_W-1:0]    count_q;
	cls_t                 cls_in;
	logic                 push;
	logic                 pop;

	// classify: below two and even words are settled here, two and three are prime
	always_comb begin
		if (number < NUM_WIDTH'(2)) begin
			cls_in = CLS_COMPOSITE;
		end else if (number < NUM_WIDTH'(4)) begin
			cls_in = CLS_PRIME;
		end else if (!number[0]) begin
			cls_in = CLS_COMPOSITE;
		end else begin
			cls_in = CLS_SEARCH;
		end
	end

	assign number_stall = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push         = number_valid && !number_stall;
	assign pop          = entry_pop && (count_q != '0);

	// queue head
	assign entry.valid  = (count_q != '0);
	assign entry.cls    = cls_q[rd_ptr_q];
	assign entry_number = num_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			num_q[wr_ptr_q] <= number;
			cls_q[wr_ptr_q] <= cls_in;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// File: design/tdp_back.sv
module tdp_back import tdp_pkg::*; #(
	parameter int NUM_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tdp_entry_t           entry,
	input  logic [NUM_WIDTH-1:0] entry_number,
	output logic                 entry_pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic                 is_prime
);

	localparam int CNT_W = $clog2(NUM_WIDTH);

	state_t               state_q;
	logic                 res_valid_q;
	logic                 res_prime_q;
	logic [NUM_WIDTH-1:0] value_q;
	logic [NUM_WIDTH-1:0] shift_q;
	logic [NUM_WIDTH-1:0] rem_q;
	logic [NUM_WIDTH-1:0] quo_q;
	logic [NUM_WIDTH-1:0] div_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [NUM_WIDTH:0]   trial;
	logic [NUM_WIDTH:0]   diff;
	logic                 fits;
	logic                 out_free;
	logic                 produce;
	logic                 prime_bit;
	logic                 start;
	logic                 last_bit;
	logic                 next_div;

	assign out_free = !res_valid_q || !result_stall;

	// one restoring division step per cycle
	assign trial    = {rem_q, shift_q[NUM_WIDTH-1]};
	assign diff     = trial - {1'b0, div_q};
	assign fits     = (trial >= {1'b0, div_q});
	assign last_bit = (cnt_q == CNT_W'(NUM_WIDTH - 1));

	// sequencer decisions
	always_comb begin
		entry_pop = 1'b0;
		produce   = 1'b0;
		prime_bit = 1'b0;
		start     = 1'b0;
		next_div  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (entry.valid) begin
					case (entry.cls)
						CLS_SEARCH: begin
							entry_pop = 1'b1;
							start     = 1'b1;
						end
						CLS_PRIME: begin
							entry_pop = out_free;
							produce   = out_free;
							prime_bit = 1'b1;
						end
						default: begin
							entry_pop = out_free;
							produce   = out_free;
						end
					endcase
				end
			end
			ST_EVAL: begin
				// divisor past the square root bound: no factor found
				if (div_q > quo_q) begin
					produce   = out_free;
					prime_bit = 1'b1;
				end else if (rem_q == '0) begin
					produce   = out_free;
				end else begin
					next_div  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// state and output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (last_bit) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (next_div) begin
						state_q <= ST_DIV;
					end else if (produce) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (produce) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// divider datapath and result payload
	always_ff @(posedge clk) begin
		if (start) begin
			value_q <= entry_number;
			shift_q <= entry_number;
			rem_q   <= '0;
			div_q   <= NUM_WIDTH'(2);
			cnt_q   <= '0;
		end else if (next_div) begin
			shift_q <= value_q;
			rem_q   <= '0;
			div_q   <= div_q + NUM_WIDTH'(1);
			cnt_q   <= '0;
		end else if (state_q == ST_DIV) begin
			shift_q <= {shift_q[NUM_WIDTH-2:0], 1'b0};
			rem_q   <= fits ? diff[NUM_WIDTH-1:0] : trial[NUM_WIDTH-1:0];
			quo_q   <= {quo_q[NUM_WIDTH-2:0], fits};
			cnt_q   <= cnt_q + CNT_W'(1);
		end
		if (produce) begin
			res_prime_q <= prime_bit;
		end
	end

	assign result_valid = res_valid_q;
	assign is_prime     = res_prime_q;

endmodule

// File: design/trial_division_prime_test.sv
// Primality test by trial division. Each number word yields one is_prime word, in order:
// 1 for a prime, 0 for a composite or for zero and one. Words below four and even words
// are settled by the front end. Odd words of five and up go to the back end, which
// divides the number by d = 2, 3, 4, ... until d exceeds the quotient or divides evenly,
// one restoring division at one bit per cycle for each divisor. A two-word queue lets the
// input run ahead while a search is under way, and an output register holds the finished
// word until it is taken.
module trial_division_prime_test import tdp_pkg::*; #(
	parameter int NUM_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 number_valid,
	output logic                 number_stall,
	input  logic [NUM_WIDTH-1:0] number,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic                 is_prime
);

	tdp_entry_t           entry;
	logic [NUM_WIDTH-1:0] entry_number;
	logic                 entry_pop;

	// accept, classify and queue
	tdp_front #(.NUM_WIDTH(NUM_WIDTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.number_valid (number_valid),
		.number_stall (number_stall),
		.number       (number),
		.entry        (entry),
		.entry_number (entry_number),
		.entry_pop    (entry_pop)
	);

	// divisor search and output register
	tdp_back #(.NUM_WIDTH(NUM_WIDTH)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.entry        (entry),
		.entry_number (entry_number),
		.entry_pop    (entry_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.is_prime     (is_prime)
	);

endmodule

// File: design/tdp_checker.sv
`include "trial_division_prime_test_macros.svh"

module tdp_checker import tdp_pkg::*; #(
	parameter int NUM_WIDTH = 32
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 number_valid,
	input logic                 number_stall,
	input logic                 result_valid,
	input logic                 result_stall,
	input logic                 is_prime
);

	// queue, back end and output register together hold at most this many words
	localparam int MAX_OUT = QUEUE_DEPTH + 2;

	logic [2:0] outstanding_q;
	logic       in_take;
	logic       out_take;

	assign in_take  = number_valid && !number_stall;
	assign out_take = result_valid && !result_stall;

	// words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (in_take && !out_take) begin
			outstanding_q <= outstanding_q + 3'd1;
		end else if (out_take && !in_take) begin
			outstanding_q <= outstanding_q - 3'd1;
		end
	end

	`TDP_ASSERT(a_result_holds, clk, arst_n, result_valid && result_stall |=> result_valid && $stable(is_prime))
	`TDP_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !result_valid && !number_stall)
	`TDP_ASSERT(a_no_invented, clk, arst_n, result_valid |-> outstanding_q != 3'd0)
	`TDP_ASSERT(a_full_stalls, clk, arst_n, outstanding_q == 3'(MAX_OUT) |-> number_stall)

endmodule

bind trial_division_prime_test tdp_checker #(.NUM_WIDTH(NUM_WIDTH)) u_tdp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.number_valid (number_valid),
	.number_stall (number_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.is_prime     (is_prime)
);

// File: tb/prime_verdict_checker.sv
module prime_verdict_checker #(
	parameter int NUM_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 number_valid,
	input  logic                 number_stall,
	input  logic [NUM_WIDTH-1:0] number,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  logic                 is_prime,
	output int unsigned          fail_count,
	output int unsigned          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// verdicts still owed by the block, oldest first
	logic expected_verdicts[$];

	// trial division, bound kept as d <= n / d so nothing overflows
	function automatic logic is_prime_by_division(input logic [NUM_WIDTH-1:0] value);
		logic [NUM_WIDTH-1:0] divisor;
		if (value < 2) begin
			return 1'b0;
		end
		for (divisor = 2; divisor <= value / divisor; divisor++) begin
			if (value % divisor == 0) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// compare the result word first, then record the accepted number word
	always @(posedge clk) begin
		logic want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_verdicts.size() == 0) begin
					$error("is_prime: no word expected, got %0d", is_prime);
					fail_count++;
				end else begin
					want = expected_verdicts.pop_front();
					if (want !== is_prime) begin
						$error("is_prime: expected %0d, got %0d", want, is_prime);
						fail_count++;
					end
				end
			end
			if (number_valid && !number_stall) begin
				expected_verdicts.push_back(is_prime_by_division(number));
			end
			pending = expected_verdicts.size();
		end
	end

endmodule

// File: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_WIDTH    = 32;
	localparam int RANDOM_WORDS = 76;
	localparam int CALM_WORDS   = 20;
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT  = 4_000_000;

	logic                 clk;
	logic                 arst_n;
	logic                 number_valid;
	logic                 number_stall;
	logic [NUM_WIDTH-1:0] number;
	logic                 result_valid;
	logic                 result_stall;
	logic                 is_prime;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned cycle_count;
	bit          idling_on;

	trial_division_prime_test #(
		.NUM_WIDTH(NUM_WIDTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.number_valid(number_valid),
		.number_stall(number_stall),
		.number      (number),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.is_prime    (is_prime)
	);

	prime_verdict_checker #(
		.NUM_WIDTH(NUM_WIDTH)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.number_valid(number_valid),
		.number_stall(number_stall),
		.number      (number),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.is_prime    (is_prime),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("FAIL trial_division_prime_test");
				$finish;
			end
		end
	end

	// receiver stalls in bursts while idling is on
	initial begin
		int unsigned burst_left;
		burst_left   = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (burst_left > 0) begin
				burst_left--;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				burst_left = $urandom_range(1, 12);
			end
			result_stall <= (burst_left > 0);
		end
	end

	// offer one number word and hold it until accepted, leaves at a falling edge
	task automatic send_number(input logic [NUM_WIDTH-1:0] value);
		int unsigned gap;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			number_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		number_valid <= 1'b1;
		number       <= value;
		do begin
			@(posedge clk);
		end while (number_stall);
		@(negedge clk);
	endtask

	// random number word, kept cheap for the block: odd large words get a small factor
	function automatic logic [NUM_WIDTH-1:0] pick_number();
		logic [NUM_WIDTH-1:0] value;
		logic [NUM_WIDTH-1:0] factor;
		logic [NUM_WIDTH-1:0] root;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: value = $urandom_range(0, 1023);
			4, 5:       value = $urandom_range(0, 65535);
			6, 7: begin
				value = $urandom();
				if (value[0]) begin
					case ($urandom_range(0, 4))
						0:       factor = 3;
						1:       factor = 5;
						2:       factor = 7;
						3:       factor = 11;
						default: factor = 13;
					endcase
					value = $urandom_range(1, 32'hFFFF_FFFF / factor) * factor;
				end
			end
			8: begin
				root  = $urandom_range(2, 300);
				value = root * root;
			end
			default: value = $urandom_range(0, 15);
		endcase
		return value;
	endfunction

	// stimulus and verdict
	initial begin
		logic [NUM_WIDTH-1:0] directed[$];
		arst_n       = 1'b1;
		number_valid = 1'b0;
		number       = '0;
		idling_on    = 1'b1;
		#1 arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// zero, one, two, three, squares, primes, extreme bit patterns
		directed = '{
			32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49,
			32'd97, 32'd121, 32'd65521, 32'd65535, 32'd1018081, 32'd1048573,
			32'd1000003, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
			32'h8000_0001, 32'hAAAA_AAAB, 32'h5555_5555, 32'd15, 32'd7
		};
		foreach (directed[i]) begin
			send_number(directed[i]);
		end

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS - CALM_WORDS) begin
				idling_on = 1'b0;
			end
			send_number(pick_number());
		end
		idling_on = 1'b0;
		number_valid <= 1'b0;

		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0) begin
			$display("PASS trial_division_prime_test");
		end else begin
			$display("FAIL trial_division_prime_test");
		end
		$finish;
	end

endmodule
